@@ sv/bdh_pkg.sv @@
// Shared types and constants for the button debounce and hat encoder block.
// Holds the register map, hat codes and the configuration struct.
// No dependencies.
package bdh_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_IDX_W = $clog2(CHANNELS);
  localparam int CNT_W = 4;
  localparam int HAT_W = 4;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  // Register indexes (byte address is four times the index).
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HAT_DIS   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HAT_UP    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HAT_DOWN  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HAT_LEFT  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HAT_RIGHT = 3'd5;

  // Hat codes.
  localparam logic [HAT_W-1:0] HAT_UP         = 4'd0;
  localparam logic [HAT_W-1:0] HAT_UP_RIGHT   = 4'd1;
  localparam logic [HAT_W-1:0] HAT_RIGHT      = 4'd2;
  localparam logic [HAT_W-1:0] HAT_DOWN_RIGHT = 4'd3;
  localparam logic [HAT_W-1:0] HAT_DOWN       = 4'd4;
  localparam logic [HAT_W-1:0] HAT_DOWN_LEFT  = 4'd5;
  localparam logic [HAT_W-1:0] HAT_LEFT       = 4'd6;
  localparam logic [HAT_W-1:0] HAT_UP_LEFT    = 4'd7;
  localparam logic [HAT_W-1:0] HAT_NEUTRAL    = 4'd15;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0]    RST_THRESHOLD = 4'd3;
  localparam logic [CH_IDX_W-1:0] RST_HAT_UP    = 4'd0;
  localparam logic [CH_IDX_W-1:0] RST_HAT_DOWN  = 4'd1;
  localparam logic [CH_IDX_W-1:0] RST_HAT_LEFT  = 4'd2;
  localparam logic [CH_IDX_W-1:0] RST_HAT_RIGHT = 4'd3;

  typedef struct packed {
    logic [CNT_W-1:0]    threshold;
    logic                hat_disabled;
    logic [CH_IDX_W-1:0] hat_up;
    logic [CH_IDX_W-1:0] hat_down;
    logic [CH_IDX_W-1:0] hat_left;
    logic [CH_IDX_W-1:0] hat_right;
  } cfg_t;

endpackage

@@ sv/button_debounce_hat_encoder_unit.sv @@
// Top level of the button debouncer with 8-way hat encoding.
// Depends on bdh_pkg, bdh_regs, bdh_debounce and bdh_hat_enc.
//
//   Channel  Signals                                   Payload
//   input    in_valid / in_ready                       raw_levels[15:0]
//   output   out_valid / out_ready                     buttons[15:0], hat_code[3:0]
//   config   psel penable pwrite paddr pwdata prdata   6 registers at 4*i
//
// One request enters per cycle while in_ready is high. A sample is held in the input
// register, then the debounce update and hat encoding run in one pass into the
// result register, which presents the result once its request has passed both.
// Reset clears the channel state and loads the register defaults.
// A stall at the output holds both stages; in_ready drops only when both are full.
module button_debounce_hat_encoder_unit
  import bdh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         raw_levels,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         buttons,
  output logic [HAT_W-1:0]    hat_code,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  cfg_t                cfg;
  logic                s1_valid;
  logic [15:0]         s1_levels;
  logic                s1_advance;
  logic [CHANNELS-1:0] deb_next;
  logic [HAT_W-1:0]    hat_next;

  bdh_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_levels <= raw_levels;
    end
  end

  // Levels are active low; the debouncer works on pressed samples.
  bdh_debounce u_debounce (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_advance),
    .sample    (~s1_levels),
    .threshold (cfg.threshold),
    .deb_next  (deb_next)
  );

  bdh_hat_enc u_hat_enc (
    .buttons  (deb_next),
    .cfg      (cfg),
    .hat_code (hat_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      buttons  <= deb_next;
      hat_code <= hat_next;
    end
  end

endmodule

@@ sv/bdh_regs.sv @@
// APB-style configuration register file for the debounce and hat encoder.
// Depends on bdh_pkg for the register map and the cfg_t struct.
module bdh_regs
  import bdh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold    <= RST_THRESHOLD;
      cfg.hat_disabled <= 1'b0;
      cfg.hat_up       <= RST_HAT_UP;
      cfg.hat_down     <= RST_HAT_DOWN;
      cfg.hat_left     <= RST_HAT_LEFT;
      cfg.hat_right    <= RST_HAT_RIGHT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_THRESHOLD: cfg.threshold    <= pwdata[CNT_W-1:0];
        REG_HAT_DIS:   cfg.hat_disabled <= pwdata[0];
        REG_HAT_UP:    cfg.hat_up       <= pwdata[CH_IDX_W-1:0];
        REG_HAT_DOWN:  cfg.hat_down     <= pwdata[CH_IDX_W-1:0];
        REG_HAT_LEFT:  cfg.hat_left     <= pwdata[CH_IDX_W-1:0];
        REG_HAT_RIGHT: cfg.hat_right    <= pwdata[CH_IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_THRESHOLD: prdata[CNT_W-1:0]    = cfg.threshold;
      REG_HAT_DIS:   prdata[0]            = cfg.hat_disabled;
      REG_HAT_UP:    prdata[CH_IDX_W-1:0] = cfg.hat_up;
      REG_HAT_DOWN:  prdata[CH_IDX_W-1:0] = cfg.hat_down;
      REG_HAT_LEFT:  prdata[CH_IDX_W-1:0] = cfg.hat_left;
      REG_HAT_RIGHT: prdata[CH_IDX_W-1:0] = cfg.hat_right;
      default:       prdata = '0;
    endcase
  end

endmodule

@@ sv/bdh_debounce.sv @@
// Per-channel debounce state: previous sample, stability counter, debounced bit.
// Depends on bdh_pkg for widths. Gives the debounced states after the update.
module bdh_debounce
  import bdh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [CHANNELS-1:0] sample,
  input  logic [CNT_W-1:0]    threshold,
  output logic [CHANNELS-1:0] deb_next
);

  logic [CHANNELS-1:0] prev_sample;
  logic [CHANNELS-1:0] deb_state;
  logic [CNT_W-1:0]    count [CHANNELS];
  logic [CNT_W-1:0]    count_next [CHANNELS];

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      // The counter saturates at the threshold, so the increment cannot wrap.
      if (sample[i] == prev_sample[i]) begin
        count_next[i] = (count[i] < threshold) ? count[i] + 1'b1 : count[i];
      end else begin
        count_next[i] = '0;
      end
      deb_next[i] = (count_next[i] >= threshold) ? sample[i] : deb_state[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
      deb_state   <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        count[i] <= '0;
      end
    end else if (step) begin
      prev_sample <= sample;
      deb_state   <= deb_next;
      for (int i = 0; i < CHANNELS; i++) begin
        count[i] <= count_next[i];
      end
    end
  end

endmodule

@@ sv/bdh_hat_enc.sv @@
// Eight-way hat encoder over four configurable button channels.
// Depends on bdh_pkg for the hat codes and the cfg_t struct.
module bdh_hat_enc
  import bdh_pkg::*;
(
  input  logic [CHANNELS-1:0] buttons,
  input  cfg_t                cfg,
  output logic [HAT_W-1:0]    hat_code
);

  logic u, d, l, r;

  assign u = buttons[cfg.hat_up];
  assign d = buttons[cfg.hat_down];
  assign l = buttons[cfg.hat_left];
  assign r = buttons[cfg.hat_right];

  always_comb begin
    if (cfg.hat_disabled) begin
      hat_code = HAT_NEUTRAL;
    end else begin
      case ({u, d, l, r})
        4'b1000: hat_code = HAT_UP;
        4'b1001: hat_code = HAT_UP_RIGHT;
        4'b0001: hat_code = HAT_RIGHT;
        4'b0101: hat_code = HAT_DOWN_RIGHT;
        4'b0100: hat_code = HAT_DOWN;
        4'b0110: hat_code = HAT_DOWN_LEFT;
        4'b0010: hat_code = HAT_LEFT;
        4'b1010: hat_code = HAT_UP_LEFT;
        default: hat_code = HAT_NEUTRAL;
      endcase
    end
  end

endmodule
